// ----- design/rpat_pkg.sv -----
// ----------------------------------------------------------------------------
// rpat_pkg
// Shared types and constants of the recent peer authentication table.
// ----------------------------------------------------------------------------
package rpat_pkg;

  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned TIME_W    = 63;
  localparam int unsigned TTL_W     = 16;
  localparam int unsigned SLOT_IDX_W = 4;

  // Window in microseconds: 16-bit seconds times one million fits in 36 bits.
  localparam int unsigned TTL_US_W  = 36;
  localparam logic [19:0] US_PER_SEC = 20'd1000000;
  localparam logic [TTL_US_W-1:0] TTL_US_RESET = 36'd300000000;

  typedef enum logic {
    OP_CHECK  = 1'b0,
    OP_RECORD = 1'b1
  } rpat_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE
  } rpat_state_e;

  // Controller to datapath.
  typedef struct packed {
    logic start;   // latch the incoming item and reset the scan
    logic step;    // examine one table entry
    logic commit;  // update the table and load the result register
  } rpat_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic zero_addr;  // latched address is zero
    logic match;      // entry under the scan pointer matches
    logic last;       // scan pointer is on the last entry
    logic out_free;   // result register can take a new result
  } rpat_sts_t;

endpackage

// ----- design/rpat_in_if.sv -----
// ----------------------------------------------------------------------------
// rpat_in_if
// Request channel: op, peer address and current time.
// ----------------------------------------------------------------------------
interface rpat_in_if;
  logic                         valid;
  logic                         ready;
  logic                         op;
  logic [rpat_pkg::ADDR_W-1:0]  peer_addr;
  logic [rpat_pkg::TIME_W-1:0]  now_us;

  modport source (output valid, output op, output peer_addr, output now_us, input ready);
  modport sink   (input valid, input op, input peer_addr, input now_us, output ready);
endinterface

// ----- design/rpat_out_if.sv -----
// ----------------------------------------------------------------------------
// rpat_out_if
// Result channel: recent flag, touched flag and slot index.
// ----------------------------------------------------------------------------
interface rpat_out_if;
  logic                            valid;
  logic                            ready;
  logic                            recent;
  logic                            slot_touched;
  logic [rpat_pkg::SLOT_IDX_W-1:0] slot_index;

  modport source (output valid, output recent, output slot_touched, output slot_index,
                  input ready);
  modport sink   (input valid, input recent, input slot_touched, input slot_index,
                  output ready);
endinterface

// ----- design/rpat_ctrl.sv -----
// ----------------------------------------------------------------------------
// rpat_ctrl
// Sequencer: accept an item, scan the table one entry a cycle, write back.
// ----------------------------------------------------------------------------
module rpat_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  rpat_pkg::rpat_sts_t sts_i,
  output rpat_pkg::rpat_cmd_t cmd_o
);
  import rpat_pkg::*;

  rpat_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // A zero address skips the scan and only produces an empty result.
        if (sts_i.zero_addr) begin
          state_d = ST_WRITE;
        end else begin
          cmd_o.step = 1'b1;
          if (sts_i.match || sts_i.last) begin
            state_d = ST_WRITE;
          end
        end
      end
      ST_WRITE: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- design/rpat_dpath.sv -----
// ----------------------------------------------------------------------------
// rpat_dpath
// Table storage, scan registers, expiry compare and the result register.
// ----------------------------------------------------------------------------
module rpat_dpath #(
  parameter int unsigned SLOTS = 4
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [rpat_pkg::TTL_W-1:0]          cfg_data_i,
  input  logic                                in_op_i,
  input  logic [rpat_pkg::ADDR_W-1:0]         in_addr_i,
  input  logic [rpat_pkg::TIME_W-1:0]         in_now_i,
  input  rpat_pkg::rpat_cmd_t                 cmd_i,
  output rpat_pkg::rpat_sts_t                 sts_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                out_recent_o,
  output logic                                out_touched_o,
  output logic [rpat_pkg::SLOT_IDX_W-1:0]     out_index_o
);
  import rpat_pkg::*;

  localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  logic [ADDR_W-1:0]   addr_store_q [SLOTS];
  logic [TIME_W-1:0]   time_store_q [SLOTS];
  logic [TTL_US_W-1:0] ttl_us_q;

  logic                op_q;
  logic [ADDR_W-1:0]   addr_q;
  logic [TIME_W-1:0]   now_q;

  logic [IDX_W-1:0]    cnt_q;
  logic                found_q;
  logic                hit_q;
  logic [IDX_W-1:0]    found_idx_q;
  logic                empty_found_q;
  logic [IDX_W-1:0]    empty_idx_q;
  logic [IDX_W-1:0]    oldest_idx_q;
  logic [TIME_W-1:0]   oldest_ts_q;

  logic                out_valid_q;
  logic                out_recent_q;
  logic                out_touched_q;
  logic [SLOT_IDX_W-1:0] out_index_q;

  logic [ADDR_W-1:0]   cur_addr;
  logic [TIME_W-1:0]   cur_time;
  logic [TIME_W:0]     expiry;
  logic                cur_hit;
  logic                cur_match;

  // Write-back decision.
  logic                wr_addr_en;
  logic                wr_time_en;
  logic [IDX_W-1:0]    wr_idx;
  logic [ADDR_W-1:0]   wr_addr;
  logic                res_recent;
  logic                res_touched;

  assign cur_addr  = addr_store_q[cnt_q];
  assign cur_time  = time_store_q[cnt_q];
  assign cur_match = (cur_addr == addr_q);

  // A stamp ahead of the current time also counts as a hit, which this compare
  // covers since the sum cannot overflow.
  assign expiry  = {1'b0, cur_time} + (TIME_W+1)'(ttl_us_q);
  assign cur_hit = ({1'b0, now_q} <= expiry);

  assign sts_o.zero_addr = (addr_q == '0);
  assign sts_o.match     = cur_match;
  assign sts_o.last      = (cnt_q == LAST_IDX);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ttl_us_q <= TTL_US_RESET;
    end else if (cfg_we_i) begin
      ttl_us_q <= TTL_US_W'({20'd0, cfg_data_i} * {16'd0, US_PER_SEC});
    end
  end

  // Item latch and scan state.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      op_q          <= in_op_i;
      addr_q        <= in_addr_i;
      now_q         <= in_now_i;
      cnt_q         <= '0;
      found_q       <= 1'b0;
      hit_q         <= 1'b0;
      found_idx_q   <= '0;
      empty_found_q <= 1'b0;
      empty_idx_q   <= '0;
      oldest_idx_q  <= '0;
      oldest_ts_q   <= '1;
    end else if (cmd_i.step) begin
      if (cur_match) begin
        found_q     <= 1'b1;
        hit_q       <= cur_hit;
        found_idx_q <= cnt_q;
      end else begin
        if ((cur_addr == '0) && !empty_found_q) begin
          empty_found_q <= 1'b1;
          empty_idx_q   <= cnt_q;
        end
        if (cur_time < oldest_ts_q) begin
          oldest_ts_q  <= cur_time;
          oldest_idx_q <= cnt_q;
        end
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_comb begin
    wr_addr_en  = 1'b0;
    wr_time_en  = 1'b0;
    wr_idx      = found_idx_q;
    wr_addr     = addr_q;
    res_recent  = 1'b0;
    res_touched = 1'b0;
    if (addr_q != '0) begin
      case (rpat_op_e'(op_q))
        OP_CHECK: begin
          if (found_q) begin
            res_touched = 1'b1;
            if (hit_q) begin
              res_recent = 1'b1;
              wr_time_en = 1'b1;
            end else begin
              // Expired entry: empty it, keep the stamp.
              wr_addr_en = 1'b1;
              wr_addr    = '0;
            end
          end
        end
        OP_RECORD: begin
          res_touched = 1'b1;
          wr_time_en  = 1'b1;
          if (!found_q) begin
            wr_addr_en = 1'b1;
            wr_idx     = empty_found_q ? empty_idx_q : oldest_idx_q;
          end
        end
        default: begin
          res_touched = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        addr_store_q[i] <= '0;
        time_store_q[i] <= '0;
      end
    end else if (cmd_i.commit) begin
      if (wr_addr_en) begin
        addr_store_q[wr_idx] <= wr_addr;
      end
      if (wr_time_en) begin
        time_store_q[wr_idx] <= now_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_recent_q  <= res_recent;
      out_touched_q <= res_touched;
      out_index_q   <= res_touched ? SLOT_IDX_W'(wr_idx) : '0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_recent_o  = out_recent_q;
  assign out_touched_o = out_touched_q;
  assign out_index_o   = out_index_q;

  // A result must never overwrite one that is still waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten while full");

  // The scan pointer never runs past the last entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step && !cur_match && (cnt_q == LAST_IDX) |=> !cmd_i.step)
    else $error("scan continued past the last entry");

  // A recent peer always comes with a touched slot.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_recent_q |-> out_touched_q)
    else $error("recent result without a touched slot");

  // An untouched result reports slot zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_touched_q |-> (out_index_q == '0))
    else $error("untouched result carries a slot index");

endmodule

// ----- design/recent_peer_auth_table_unit.sv -----
// ----------------------------------------------------------------------------
// recent_peer_auth_table_unit
// Table of recently authenticated peers with time-to-live check and refresh.
//
//   Channel   Dir  Handshake          Payload
//   in_ch     in   valid/ready        op, peer_addr, now_us
//   out_ch    out  valid/ready        recent, slot_touched, slot_index
//   cfg       in   cfg_we_i (write)   cfg_data_i = ttl_seconds
//
// An item is latched, then the scan examines one table entry at a time up to
// the first matching entry or the last entry, and then it is written back.
// A zero address skips the scan. The scan uses a single entry compare and
// scan pointer. The table is cleared by reset at once. A result waits in
// the output register while the next item is already accepted; only the
// write-back cycle stalls until the output register is free.
// ----------------------------------------------------------------------------
module recent_peer_auth_table_unit #(
  parameter int unsigned SLOTS = 4
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  rpat_in_if.sink                     in_ch,
  rpat_out_if.source                  out_ch,
  input  logic                        cfg_we_i,
  input  logic [rpat_pkg::TTL_W-1:0]  cfg_data_i
);
  import rpat_pkg::*;

  rpat_cmd_t cmd;
  rpat_sts_t sts;
  logic      in_ready;

  rpat_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rpat_dpath #(
    .SLOTS (SLOTS)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_data_i    (cfg_data_i),
    .in_op_i       (in_ch.op),
    .in_addr_i     (in_ch.peer_addr),
    .in_now_i      (in_ch.now_us),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_valid_o   (out_ch.valid),
    .out_ready_i   (out_ch.ready),
    .out_recent_o  (out_ch.recent),
    .out_touched_o (out_ch.slot_touched),
    .out_index_o   (out_ch.slot_index)
  );

  assign in_ch.ready = in_ready;

endmodule
